FILE: sv/fracsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fracsm_pkg
// Shared types and constants for the fraction sum and max block.
// ----------------------------------------------------------------------------
package fracsm_pkg;

  localparam int SUM_WIDTH_DEF = 64;
  localparam int NUM_W         = 32;
  localparam int DP_W          = 64;
  localparam int MAG_W         = DP_W + NUM_W;
  localparam int DIV_STEPS     = DP_W;
  localparam int DIV_CNT_W     = $clog2(DIV_STEPS + 1);

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_OVF  = 2'd1;
  localparam logic [1:0] STATUS_ZERO = 2'd2;

  // product slots of one request
  localparam logic [2:0] PROD_P  = 3'd0;
  localparam logic [2:0] PROD_Q  = 3'd1;
  localparam logic [2:0] PROD_T1 = 3'd2;
  localparam logic [2:0] PROD_T2 = 3'd3;
  localparam logic [2:0] PROD_ND = 3'd4;

  // phases of one product
  localparam logic [1:0] PH_LO  = 2'd0;
  localparam logic [1:0] PH_HI  = 2'd1;
  localparam logic [1:0] PH_ADD = 2'd2;
  localparam logic [1:0] PH_RES = 2'd3;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MUL  = 8'b0000_0010,
    S_UPD  = 8'b0000_0100,
    S_CHK  = 8'b0000_1000,
    S_REM  = 8'b0001_0000,
    S_QN   = 8'b0010_0000,
    S_QD   = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_e;

  function automatic logic [DP_W-1:0] mag64(input logic [DP_W-1:0] v);
    return v[DP_W-1] ? (DP_W'(0) - v) : v;
  endfunction

  function automatic logic [NUM_W-1:0] mag32(input logic [NUM_W-1:0] v);
    return v[NUM_W-1] ? (NUM_W'(0) - v) : v;
  endfunction

endpackage

FILE: sv/fraction_sum_and_max.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction_sum_and_max
// Largest fraction and exact, gcd-reduced sum over a stream of fractions.
// ----------------------------------------------------------------------------
// One request is taken at a time. A request runs five products through one
// shared 32x32 multiplier, each in low-half, high-half, add and result
// phases, after the accept state and before the update state. A request with
// last set then runs a Euclid gcd and two divisions on a bit-serial 64-step
// divider. The result sits in an output register; the block takes new
// requests while it waits, and a later final result waits only for that
// register.
// ----------------------------------------------------------------------------
module fraction_sum_and_max
  import fracsm_pkg::*;
#(
  parameter int SUM_WIDTH = SUM_WIDTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [31:0]      numer_i,
  input  logic signed [31:0]      denom_i,
  input  logic                    last_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [31:0]      max_numer_o,
  output logic signed [31:0]      max_denom_o,
  output logic signed [63:0]      sum_numer_o,
  output logic signed [63:0]      sum_denom_o,
  output logic [1:0]              status_o
);

  localparam logic [MAG_W-1:0] POS_LIM = (MAG_W'(1) << (SUM_WIDTH - 1)) - MAG_W'(1);
  localparam logic [MAG_W-1:0] NEG_LIM = MAG_W'(1) << (SUM_WIDTH - 1);

  function automatic logic fits_mag(input logic [MAG_W-1:0] m, input logic neg);
    return neg ? (m <= NEG_LIM) : (m <= POS_LIM);
  endfunction

  state_e state_q;

  logic [NUM_W-1:0]     n_q, d_q, best_n_q, best_d_q;
  logic                 last_q, first_q, ovf_q, zds_q, mul_fail_q;
  logic [SUM_WIDTH-1:0] acc_n_q, acc_d_q;

  logic [2:0]           idx_q;
  logic [1:0]           ph_q;
  logic [DP_W-1:0]      prod_q;
  logic [DP_W-1:0]      lo_q;
  logic [MAG_W-1:0]     mag_q;
  logic [DP_W-1:0]      p_q, q_q, t1_q, t2_q, nd_q;

  logic [DP_W-1:0]      ga_q, gb_q, sum_n_q, sum_d_q;
  logic [DP_W-1:0]      div_quo_q, div_rem_q, div_dvs_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;

  logic                 out_valid_q;
  logic [NUM_W-1:0]     out_max_n_q, out_max_d_q;
  logic [DP_W-1:0]      out_sum_n_q, out_sum_d_q;
  logic [1:0]           out_status_q;

  // multiplier operand select
  logic [DP_W-1:0]      px;
  logic [NUM_W-1:0]     py;
  logic [DP_W-1:0]      ux;
  logic [NUM_W-1:0]     mul_a;
  logic [DP_W-1:0]      mul_out;
  logic                 prod_neg, prod_fits;
  logic [DP_W-1:0]      prod_res;

  always_comb begin
    case (idx_q)
      PROD_P: begin
        px = DP_W'($signed(n_q));
        py = best_d_q;
      end
      PROD_Q: begin
        px = DP_W'($signed(best_n_q));
        py = d_q;
      end
      PROD_T1: begin
        px = DP_W'($signed(acc_n_q));
        py = d_q;
      end
      PROD_T2: begin
        px = DP_W'($signed(acc_d_q));
        py = n_q;
      end
      PROD_ND: begin
        px = DP_W'($signed(acc_d_q));
        py = d_q;
      end
      default: begin
        px = '0;
        py = '0;
      end
    endcase
  end

  assign ux        = mag64(px);
  assign mul_a     = (ph_q == PH_HI) ? ux[DP_W-1:NUM_W] : ux[NUM_W-1:0];
  assign mul_out   = mul_a * mag32(py);
  assign prod_neg  = px[DP_W-1] ^ py[NUM_W-1];
  assign prod_fits = fits_mag(mag_q, prod_neg);
  assign prod_res  = prod_neg ? (DP_W'(0) - mag_q[DP_W-1:0]) : mag_q[DP_W-1:0];

  // max compare and sum update
  logic                 cmp_dz, cmp_gt;
  logic signed [DP_W:0] add_s;
  logic signed [DP_W:0] add_top;
  logic                 add_fits;

  assign cmp_dz   = (d_q == '0) || (best_d_q == '0);
  assign cmp_gt   = !cmp_dz && ((d_q[NUM_W-1] ^ best_d_q[NUM_W-1]) ?
                    ($signed(p_q) < $signed(q_q)) : ($signed(p_q) > $signed(q_q)));
  assign add_s    = $signed({t1_q[DP_W-1], t1_q}) + $signed({t2_q[DP_W-1], t2_q});
  assign add_top  = add_s >>> (SUM_WIDTH - 1);
  assign add_fits = (add_top == '0) || (add_top == '1);

  // bit-serial divider step
  logic [DP_W:0]   div_sh, div_diff;
  logic            div_ge;
  logic            div_done;
  logic [DP_W-1:0] acc_n64, acc_d64, rem_s;
  logic [DP_W-1:0] quo_s;
  logic            quo_neg;

  assign div_sh   = {div_rem_q, div_quo_q[DP_W-1]};
  assign div_diff = div_sh - {1'b0, div_dvs_q};
  assign div_ge   = !div_diff[DP_W];
  assign div_done = (div_cnt_q == DIV_CNT_W'(DIV_STEPS));
  assign acc_n64  = DP_W'($signed(acc_n_q));
  assign acc_d64  = DP_W'($signed(acc_d_q));
  assign rem_s    = ga_q[DP_W-1] ? (DP_W'(0) - div_rem_q) : div_rem_q;
  assign quo_neg  = ((state_q == S_QN) ? acc_n64[DP_W-1] : acc_d64[DP_W-1]) ^ gb_q[DP_W-1];
  assign quo_s    = quo_neg ? (DP_W'(0) - div_quo_q) : div_quo_q;

  logic [1:0] fin_status;
  assign fin_status = zds_q ? STATUS_ZERO : (ovf_q ? STATUS_OVF : STATUS_OK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      n_q          <= '0;
      d_q          <= '0;
      last_q       <= 1'b0;
      best_n_q     <= '0;
      best_d_q     <= NUM_W'(1);
      acc_n_q      <= '0;
      acc_d_q      <= SUM_WIDTH'(1);
      first_q      <= 1'b1;
      ovf_q        <= 1'b0;
      zds_q        <= 1'b0;
      mul_fail_q   <= 1'b0;
      idx_q        <= PROD_P;
      ph_q         <= PH_LO;
      prod_q       <= '0;
      lo_q         <= '0;
      mag_q        <= '0;
      p_q          <= '0;
      q_q          <= '0;
      t1_q         <= '0;
      t2_q         <= '0;
      nd_q         <= '0;
      ga_q         <= '0;
      gb_q         <= '0;
      sum_n_q      <= '0;
      sum_d_q      <= '0;
      div_quo_q    <= '0;
      div_rem_q    <= '0;
      div_dvs_q    <= '0;
      div_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
      out_max_n_q  <= '0;
      out_max_d_q  <= '0;
      out_sum_n_q  <= '0;
      out_sum_d_q  <= '0;
      out_status_q <= STATUS_OK;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_FIN) begin
        out_valid_q <= 1'b0;
      end
      if ((state_q == S_REM || state_q == S_QN || state_q == S_QD) && !div_done) begin
        div_rem_q <= div_ge ? div_diff[DP_W-1:0] : div_sh[DP_W-1:0];
        div_quo_q <= {div_quo_q[DP_W-2:0], div_ge};
        div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            n_q        <= numer_i;
            d_q        <= denom_i;
            last_q     <= last_i;
            mul_fail_q <= 1'b0;
            if (denom_i == '0) begin
              zds_q <= 1'b1;
            end
            idx_q   <= PROD_P;
            ph_q    <= PH_LO;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          ph_q <= ph_q + 2'd1;
          case (ph_q)
            PH_LO: begin
              prod_q <= mul_out;
            end
            PH_HI: begin
              lo_q   <= prod_q;
              prod_q <= mul_out;
            end
            PH_ADD: begin
              mag_q <= {prod_q, NUM_W'(0)} + {NUM_W'(0), lo_q};
            end
            PH_RES: begin
              case (idx_q)
                PROD_P:  p_q <= prod_res;
                PROD_Q:  q_q <= prod_res;
                PROD_T1: begin
                  t1_q       <= prod_res;
                  mul_fail_q <= mul_fail_q | !prod_fits;
                end
                PROD_T2: begin
                  t2_q       <= prod_res;
                  mul_fail_q <= mul_fail_q | !prod_fits;
                end
                PROD_ND: begin
                  nd_q       <= prod_res;
                  mul_fail_q <= mul_fail_q | !prod_fits;
                end
                default: ;
              endcase
              if (idx_q == PROD_ND) begin
                state_q <= S_UPD;
              end else begin
                idx_q <= idx_q + 3'd1;
              end
            end
            default: ;
          endcase
        end
        S_UPD: begin
          if (first_q || cmp_gt) begin
            best_n_q <= n_q;
            best_d_q <= d_q;
          end
          first_q <= 1'b0;
          if (!ovf_q && !zds_q) begin
            if (mul_fail_q || !add_fits) begin
              ovf_q <= 1'b1;
            end else begin
              acc_n_q <= add_s[SUM_WIDTH-1:0];
              acc_d_q <= nd_q[SUM_WIDTH-1:0];
            end
          end
          state_q <= last_q ? S_CHK : S_IDLE;
        end
        S_CHK: begin
          if (ovf_q || zds_q) begin
            state_q <= S_FIN;
          end else begin
            ga_q      <= acc_n64;
            gb_q      <= acc_d64;
            div_quo_q <= mag64(acc_n64);
            div_rem_q <= '0;
            div_dvs_q <= mag64(acc_d64);
            div_cnt_q <= '0;
            state_q   <= S_REM;
          end
        end
        S_REM: begin
          if (div_done) begin
            div_rem_q <= '0;
            div_cnt_q <= '0;
            if (div_rem_q == '0) begin
              div_quo_q <= mag64(acc_n64);
              div_dvs_q <= mag64(gb_q);
              state_q   <= S_QN;
            end else begin
              ga_q      <= gb_q;
              gb_q      <= rem_s;
              div_quo_q <= mag64(gb_q);
              div_dvs_q <= div_rem_q;
            end
          end
        end
        S_QN: begin
          if (div_done) begin
            sum_n_q <= quo_s;
            if (!fits_mag(MAG_W'(div_quo_q), quo_neg)) begin
              ovf_q <= 1'b1;
            end
            div_quo_q <= mag64(acc_d64);
            div_rem_q <= '0;
            div_dvs_q <= mag64(gb_q);
            div_cnt_q <= '0;
            state_q   <= S_QD;
          end
        end
        S_QD: begin
          if (div_done) begin
            sum_d_q <= quo_s;
            if (!fits_mag(MAG_W'(div_quo_q), quo_neg)) begin
              ovf_q <= 1'b1;
            end
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q  <= 1'b1;
            out_max_n_q  <= best_n_q;
            out_max_d_q  <= best_d_q;
            out_sum_n_q  <= (fin_status == STATUS_OK) ? sum_n_q : '0;
            out_sum_d_q  <= (fin_status == STATUS_OK) ? sum_d_q : '0;
            out_status_q <= fin_status;
            best_n_q     <= '0;
            best_d_q     <= NUM_W'(1);
            acc_n_q      <= '0;
            acc_d_q      <= SUM_WIDTH'(1);
            first_q      <= 1'b1;
            ovf_q        <= 1'b0;
            zds_q        <= 1'b0;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign max_numer_o = out_max_n_q;
  assign max_denom_o = out_max_d_q;
  assign sum_numer_o = out_sum_n_q;
  assign sum_denom_o = out_sum_d_q;
  assign status_o    = out_status_q;

endmodule

FILE: tb/fracsm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fracsm_checker
// Watches both channels of fraction_sum_and_max, predicts each set result and
// compares it field by field with what the block returns. Every accepted
// request is folded into a local copy of the running max and exact sum; a
// request with last set closes the set and queues the expected result. The
// count of mismatches and of results still due goes back to the bench top.
// ----------------------------------------------------------------------------
module fracsm_checker
  import fracsm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic signed [31:0] numer_i,
  input  logic signed [31:0] denom_i,
  input  logic               last_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [31:0] max_numer_i,
  input  logic signed [31:0] max_denom_i,
  input  logic signed [63:0] sum_numer_i,
  input  logic signed [63:0] sum_denom_i,
  input  logic [1:0]         status_i,
  output int                 errors_o,
  output int                 pending_o,
  output int                 sets_ok_o,
  output int                 sets_ovf_o,
  output int                 sets_zero_o
);

  localparam int SW = SUM_WIDTH_DEF;

  typedef struct packed {
    logic signed [31:0] max_n;
    logic signed [31:0] max_d;
    logic signed [63:0] sum_n;
    logic signed [63:0] sum_d;
    logic [1:0]         status;
  } set_result_t;

  set_result_t results_due[$];
  set_result_t want;

  longint top_n, top_d, run_n, run_d;
  bit     fresh_set, sum_ovf, saw_zero_den;
  int     errs, n_ok, n_ovf, n_zero;

  function automatic bit in_sum_range(input logic signed [127:0] v);
    logic signed [127:0] hi;
    hi = v >>> (SW - 1);
    return (hi == 0) || (hi == -1);
  endfunction

  function automatic bit mul_fits(input longint x, input longint y, output longint r);
    logic signed [127:0] p;
    p = x;
    p = p * y;
    r = p[63:0];
    return in_sum_range(p);
  endfunction

  function automatic bit quot_fits(input longint a, input longint g, output longint q);
    logic signed [127:0] w;
    q = 0;
    if (g == 0) return 1'b0;
    w = a;
    w = w / g;
    q = w[63:0];
    return in_sum_range(w);
  endfunction

  function automatic longint trunc_rem(input longint a, input longint b);
    if (b == 0 || b == -1) return 0;
    return a % b;
  endfunction

  // exact a/b > c/e, never true with a zero denominator on either side
  function automatic bit beats(input longint n, input longint d,
                               input longint bn, input longint bd);
    longint p, q;
    if (d == 0 || bd == 0) return 1'b0;
    p = n * bd;
    q = bn * d;
    return ((d < 0) != (bd < 0)) ? (p < q) : (p > q);
  endfunction

  task automatic clear_set();
    top_n        = 0;
    top_d        = 1;
    run_n        = 0;
    run_d        = 1;
    fresh_set    = 1'b1;
    sum_ovf      = 1'b0;
    saw_zero_den = 1'b0;
  endtask

  task automatic fold_fraction(input longint n, input longint d, input bit fin);
    longint              t1, t2, nd, sn, sd, a, b, r;
    logic signed [127:0] s;
    bit                  ok;
    set_result_t         res;
    if (fresh_set || beats(n, d, top_n, top_d)) begin
      top_n = n;
      top_d = d;
    end
    fresh_set = 1'b0;
    if (d == 0) saw_zero_den = 1'b1;
    if (!sum_ovf && !saw_zero_den) begin
      ok = mul_fits(run_n, d, t1);
      ok = mul_fits(run_d, n, t2) && ok;
      s  = t1;
      s  = s + t2;
      ok = ok && in_sum_range(s);
      ok = mul_fits(run_d, d, nd) && ok;
      if (ok) begin
        run_n = s[63:0];
        run_d = nd;
      end else begin
        sum_ovf = 1'b1;
      end
    end
    if (!fin) return;

    sn = 0;
    sd = 0;
    if (!sum_ovf && !saw_zero_den) begin
      a = run_n;
      b = run_d;
      r = trunc_rem(a, b);
      while (r != 0) begin
        a = b;
        b = r;
        r = trunc_rem(a, b);
      end
      ok = quot_fits(run_n, b, sn);
      ok = quot_fits(run_d, b, sd) && ok;
      if (!ok) sum_ovf = 1'b1;
    end
    res.status = saw_zero_den ? STATUS_ZERO : (sum_ovf ? STATUS_OVF : STATUS_OK);
    if (res.status != STATUS_OK) begin
      sn = 0;
      sd = 0;
    end
    res.max_n = top_n[31:0];
    res.max_d = top_d[31:0];
    res.sum_n = sn;
    res.sum_d = sd;
    results_due.push_back(res);
    clear_set();
  endtask

  task automatic check_field(input string name, input logic signed [63:0] exp_v,
                             input logic signed [63:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      errs++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_set();
      results_due.delete();
      errs   = 0;
      n_ok   = 0;
      n_ovf  = 0;
      n_zero = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (results_due.size() == 0) begin
          $error("result returned with no fraction set pending");
          errs++;
        end else begin
          want = results_due.pop_front();
          check_field("max_numer", want.max_n, max_numer_i);
          check_field("max_denom", want.max_d, max_denom_i);
          check_field("sum_numer", want.sum_n, sum_numer_i);
          check_field("sum_denom", want.sum_d, sum_denom_i);
          check_field("status", {62'd0, want.status}, {62'd0, status_i});
          case (want.status)
            STATUS_OK:   n_ok++;
            STATUS_OVF:  n_ovf++;
            STATUS_ZERO: n_zero++;
            default: ;
          endcase
        end
      end
      if (in_valid_i && !in_stall_i) fold_fraction(numer_i, denom_i, last_i);
    end
    errors_o    <= errs;
    pending_o   <= results_due.size();
    sets_ok_o   <= n_ok;
    sets_ovf_o  <= n_ovf;
    sets_zero_o <= n_zero;
  end

endmodule

FILE: tb/tb_fraction_sum_and_max.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fraction_sum_and_max
// Stimulus and verdict for the fraction sum and max block.
// A directed opener hits the field extremes, ties, negative and zero
// denominators, a zero sum and sum overflow. Random fraction sets of mixed
// value spans follow, under four idle/stall mixes and one long output
// hold-off that backs the block up. Checking lives in fracsm_checker.
// ----------------------------------------------------------------------------
module tb_fraction_sum_and_max;
  import fracsm_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int ITEMS          = 1050;
  localparam int HOLD_CYCLES    = 3000;
  localparam int WATCHDOG_LIMIT = 25000;
  localparam int DRAIN_CYCLES   = 300;

  localparam logic signed [31:0] NUM_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] NUM_MAX = 32'sh7fff_ffff;

  typedef enum int {SPAN_SMALL, SPAN_MEDIUM, SPAN_FULL} value_span_e;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [31:0] numer;
  logic signed [31:0] denom;
  logic               last;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] max_numer;
  logic signed [31:0] max_denom;
  logic signed [63:0] sum_numer;
  logic signed [63:0] sum_denom;
  logic [1:0]         status;

  int idle_pct;
  int stall_pct;
  int requests_sent;
  int quiet_cycles;
  bit hold_mode;
  bit hold_done;

  int errors, pending, sets_ok, sets_ovf, sets_zero;

  fraction_sum_and_max dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .numer_i     (numer),
    .denom_i     (denom),
    .last_i      (last),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .max_numer_o (max_numer),
    .max_denom_o (max_denom),
    .sum_numer_o (sum_numer),
    .sum_denom_o (sum_denom),
    .status_o    (status)
  );

  fracsm_checker chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .numer_i     (numer),
    .denom_i     (denom),
    .last_i      (last),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .max_numer_i (max_numer),
    .max_denom_i (max_denom),
    .sum_numer_i (sum_numer),
    .sum_denom_i (sum_denom),
    .status_i    (status),
    .errors_o    (errors),
    .pending_o   (pending),
    .sets_ok_o   (sets_ok),
    .sets_ovf_o  (sets_ovf),
    .sets_zero_o (sets_zero)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", quiet_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  // result side: random stall, or one long hold-off on request
  initial begin
    out_stall = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_mode && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic logic signed [31:0] draw_value(input value_span_e span);
    case (span)
      SPAN_SMALL:  return int'($urandom_range(24)) - 12;
      SPAN_MEDIUM: return int'($urandom_range(65535)) - 32768;
      default: begin
        case ($urandom_range(7))
          0:       return NUM_MIN;
          1:       return NUM_MAX;
          2:       return 0;
          3:       return 1;
          4:       return -1;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  task automatic send_fraction(input logic signed [31:0] n, input logic signed [31:0] d,
                               input logic fin);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    numer    <= n;
    denom    <= d;
    last     <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
  endtask

  task automatic send_random_set();
    value_span_e span;
    int          len;
    int          roll;
    roll = $urandom_range(99);
    span = (roll < 55) ? SPAN_SMALL : ((roll < 80) ? SPAN_MEDIUM : SPAN_FULL);
    len  = $urandom_range(5, 1);
    for (int i = 0; i < len; i++) send_fraction(draw_value(span), draw_value(span), i == len - 1);
  endtask

  initial begin
    int k;
    int ph;
    int directed;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    numer         = '0;
    denom         = '0;
    last          = 1'b0;
    idle_pct      = 0;
    stall_pct     = 0;
    hold_mode     = 1'b0;
    requests_sent = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_fraction(3, 4, 1'b1);
    send_fraction(NUM_MIN, NUM_MAX, 1'b1);
    send_fraction(NUM_MAX, NUM_MIN, 1'b1);
    send_fraction(NUM_MIN, -1, 1'b1);
    send_fraction(-4, -6, 1'b1);
    // equal fractions: the earlier one stays
    send_fraction(1, 2, 1'b0);
    send_fraction(2, 4, 1'b1);
    send_fraction(1, -3, 1'b0);
    send_fraction(-1, 3, 1'b0);
    send_fraction(2, -1, 1'b1);
    send_fraction(5, 0, 1'b0);
    send_fraction(1, 2, 1'b1);
    send_fraction(1, 2, 1'b0);
    send_fraction(7, 0, 1'b1);
    send_fraction(1, 2, 1'b0);
    send_fraction(-1, 2, 1'b1);
    for (k = 0; k < 3; k++) send_fraction(NUM_MAX, NUM_MIN, k == 2);
    // overflow, then a zero denominator in the same set
    for (k = 0; k < 3; k++) send_fraction(NUM_MAX, NUM_MIN, 1'b0);
    send_fraction(1, 0, 1'b1);
    directed = requests_sent;

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 49; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 49; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      while (requests_sent < directed + (ph + 1) * (ITEMS - directed) / 4) send_random_set();
      if (ph == 0) begin
        hold_mode = 1'b1;
        for (k = 0; k < 12; k++) begin
          send_fraction(draw_value(SPAN_SMALL), draw_value(SPAN_SMALL), k % 3 == 2);
        end
        wait (hold_done);
        hold_mode = 1'b0;
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d fractions in, %0d sets checked: %0d exact sums, %0d overflowed, %0d zero denom",
             requests_sent, sets_ok + sets_ovf + sets_zero, sets_ok, sets_ovf, sets_zero);
    $display("mismatches: %0d, across open, sender-idle, receiver-stall, mixed and hold-off runs",
             errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/fracsm_pkg.sv
sv/fraction_sum_and_max.sv
tb/fracsm_checker.sv
tb/tb_fraction_sum_and_max.sv
